FILE: design/q4k_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package q4k_pkg;

    localparam int IN_DATA_W  = 136;
    localparam int OUT_DATA_W = 40;

    localparam int MAG_W   = 52;
    localparam int SC_W    = 17;
    localparam int PROD_W  = 21;
    localparam int SHIFT_W = 6;

    // value = mag * 2^(eeff - 25); leading one at bit 51 gives +51, bias +127
    localparam logic [8:0] EXP_OFFSET = 9'd153;

    localparam logic [31:0] CANON_NAN = 32'h7FC0_0000;
    localparam logic [30:0] INF_BITS  = 31'h7F80_0000;

    localparam logic [6:0] LAST_POS = 7'd127;

    typedef struct packed {
        logic load_hdr;
        logic load_quant;
        logic do_scale;
        logic do_prod;
        logic do_align;
        logic do_norm;
        logic do_round;
        logic sel_hi;
    } cmd_t;

    typedef struct packed {
        logic norm_done;
        logic out_free;
    } stat_t;

endpackage

`default_nettype wire

FILE: design/q4k_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module q4k_ctrl
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    input  wire logic          in_header,
    output logic               in_ready,
    input  wire q4k_pkg::stat_t stat,
    output q4k_pkg::cmd_t      cmd
);

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_SCALE = 6'b000010,
        ST_PROD  = 6'b000100,
        ST_ALIGN = 6'b001000,
        ST_NORM  = 6'b010000,
        ST_ROUND = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    logic   hi_reg, hi_next;
    logic   fire;

    assign in_ready = (state_reg == ST_IDLE);
    assign fire     = in_valid && in_ready;

    always_comb
    begin
        state_next     = state_reg;
        hi_next        = hi_reg;
        cmd            = '0;
        cmd.sel_hi     = hi_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.load_hdr   = fire && in_header;
                cmd.load_quant = fire && !in_header;
                if (fire && !in_header)
                begin
                    state_next = ST_SCALE;
                end
            end
            ST_SCALE:
            begin
                cmd.do_scale = 1'b1;
                hi_next      = 1'b0;
                state_next   = ST_PROD;
            end
            ST_PROD:
            begin
                cmd.do_prod = 1'b1;
                state_next  = ST_ALIGN;
            end
            ST_ALIGN:
            begin
                cmd.do_align = 1'b1;
                state_next   = ST_NORM;
            end
            ST_NORM:
            begin
                cmd.do_norm = 1'b1;
                if (stat.norm_done)
                begin
                    state_next = ST_ROUND;
                end
            end
            ST_ROUND:
            begin
                // wait for a free output slot
                if (stat.out_free)
                begin
                    cmd.do_round = 1'b1;
                    if (hi_reg)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        hi_next    = 1'b1;
                        state_next = ST_PROD;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            hi_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            hi_reg    <= hi_next;
        end
    end

endmodule

`default_nettype wire

FILE: design/q4k_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module q4k_dp
(
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire q4k_pkg::cmd_t                      cmd,
    output q4k_pkg::stat_t                          stat,
    input  wire logic [q4k_pkg::IN_DATA_W-1:0]      in_data,
    output logic [q4k_pkg::OUT_DATA_W-1:0]          out_data,
    output logic                                    out_last,
    output logic                                    out_valid,
    input  wire logic                               out_ready
);

    localparam int MW = q4k_pkg::MAG_W;

    // header state
    logic [15:0] hs_reg, hs_next;
    logic [15:0] hm_reg, hm_next;
    logic [5:0]  scl_reg [8];
    logic [5:0]  scl_next [8];
    logic [5:0]  mnl_reg [8];
    logic [5:0]  mnl_next [8];
    logic [6:0]  pos_reg, pos_next;

    // per item work registers
    logic [6:0]                      cur_reg, cur_next;
    logic [7:0]                      q_reg, q_next;
    logic [q4k_pkg::SC_W-1:0]        sc_reg, sc_next;
    logic [q4k_pkg::SC_W-1:0]        mn_reg, mn_next;
    logic [q4k_pkg::PROD_W-1:0]      p_reg, p_next;
    logic [MW-1:0]                   mag_reg, mag_next;
    logic                            sgn_reg, sgn_next;
    logic [4:0]                      emin_reg, emin_next;
    logic [q4k_pkg::SHIFT_W-1:0]     sh_reg, sh_next;
    logic                            nan_reg, nan_next;
    logic                            inf_reg, inf_next;
    logic                            infs_reg, infs_next;

    logic [q4k_pkg::OUT_DATA_W-1:0]  od_reg, od_next;
    logic                            ol_reg, ol_next;
    logic                            ov_reg, ov_next;

    logic [7:0]  b [12];
    logic [4:0]  d_ex, m_ex, d_e, m_e;
    logic [10:0] d_m, m_m;
    logic        d_nan, d_inf, m_nan, m_inf;
    logic [2:0]  sub;
    logic [3:0]  qn;
    logic [4:0]  shp, shm;
    logic [MW-1:0] a_al, b_al, sum_mag;
    logic        sa, sb, sum_sgn;
    logic        p_nan, p_inf, n_nan, n_inf;
    logic [2:0]  fsh;
    logic [MW-1:0] nrm;
    logic [8:0]  exp_b;
    logic [22:0] mant;
    logic        rnd_up;
    logic [30:0] rounded;
    logic [31:0] val;

    always_comb
    begin
        for (int j = 0; j < 4; j++)
        begin
            b[j]     = in_data[32 + 8*j +: 8];
            b[j + 4] = in_data[64 + 8*j +: 8];
            b[j + 8] = in_data[96 + 8*j +: 8];
        end
    end

    assign d_ex  = hs_reg[14:10];
    assign m_ex  = hm_reg[14:10];
    assign d_nan = (d_ex == 5'd31) && (hs_reg[9:0] != '0);
    assign d_inf = (d_ex == 5'd31) && (hs_reg[9:0] == '0);
    assign m_nan = (m_ex == 5'd31) && (hm_reg[9:0] != '0);
    assign m_inf = (m_ex == 5'd31) && (hm_reg[9:0] == '0);
    assign d_m   = {d_ex != '0, hs_reg[9:0]};
    assign m_m   = {m_ex != '0, hm_reg[9:0]};
    assign d_e   = (d_ex == '0) ? 5'd1 : d_ex;
    assign m_e   = (m_ex == '0) ? 5'd1 : m_ex;

    assign sub = cur_reg[6:4];
    assign qn  = cmd.sel_hi ? q_reg[7:4] : q_reg[3:0];

    // alignment to the smaller exponent; products are exact integers
    always_comb
    begin
        if (d_e >= m_e)
        begin
            shp       = d_e - m_e;
            shm       = '0;
            emin_next = m_e;
        end
        else
        begin
            shp       = '0;
            shm       = m_e - d_e;
            emin_next = d_e;
        end
        a_al = MW'(p_reg) << shp;
        b_al = MW'(mn_reg) << shm;
        sa   = hs_reg[15];
        sb   = !hm_reg[15];
        if (sa == sb)
        begin
            sum_mag = a_al + b_al;
            sum_sgn = sa;
        end
        else if (a_al >= b_al)
        begin
            sum_mag = a_al - b_al;
            sum_sgn = (a_al == b_al) ? 1'b0 : sa;
        end
        else
        begin
            sum_mag = b_al - a_al;
            sum_sgn = sb;
        end
        p_nan = d_nan || (d_inf && (p_reg == '0));
        p_inf = d_inf && (p_reg != '0);
        n_nan = m_nan || (m_inf && (mn_reg == '0));
        n_inf = m_inf && (mn_reg != '0);
    end

    assign stat.norm_done = (mag_reg[MW-1:MW-8] != '0) || (mag_reg == '0);
    assign stat.out_free  = !ov_reg || out_ready;

    // final normalize within the top byte and round to nearest even
    always_comb
    begin
        fsh = '0;
        for (int i = 0; i < 8; i++)
        begin
            if (mag_reg[MW-8+i])
            begin
                fsh = 3'(7 - i);
            end
        end
        nrm     = mag_reg << fsh;
        exp_b   = 9'(emin_reg) + q4k_pkg::EXP_OFFSET - 9'(sh_reg) - 9'(fsh);
        mant    = nrm[MW-2:MW-24];
        rnd_up  = nrm[MW-25] && ((nrm[MW-26:0] != '0) || mant[0]);
        rounded = {exp_b[7:0], mant} + 31'(rnd_up);
        if (nan_reg)
        begin
            val = q4k_pkg::CANON_NAN;
        end
        else if (inf_reg)
        begin
            val = {infs_reg, q4k_pkg::INF_BITS};
        end
        else if (mag_reg == '0)
        begin
            val = {sgn_reg, 31'd0};
        end
        else
        begin
            val = {sgn_reg, rounded};
        end
    end

    always_comb
    begin
        hs_next   = hs_reg;
        hm_next   = hm_reg;
        scl_next  = scl_reg;
        mnl_next  = mnl_reg;
        pos_next  = pos_reg;
        cur_next  = cur_reg;
        q_next    = q_reg;
        sc_next   = sc_reg;
        mn_next   = mn_reg;
        p_next    = p_reg;
        mag_next  = mag_reg;
        sgn_next  = sgn_reg;
        sh_next   = sh_reg;
        nan_next  = nan_reg;
        inf_next  = inf_reg;
        infs_next = infs_reg;
        od_next   = od_reg;
        ol_next   = ol_reg;
        ov_next   = out_ready ? 1'b0 : ov_reg;

        if (cmd.load_hdr)
        begin
            hs_next  = in_data[15:0];
            hm_next  = in_data[31:16];
            pos_next = '0;
            for (int j = 0; j < 4; j++)
            begin
                scl_next[j]     = b[j][5:0];
                mnl_next[j]     = b[j + 4][5:0];
                scl_next[j + 4] = {b[j][7:6], b[j + 8][3:0]};
                mnl_next[j + 4] = {b[j + 4][7:6], b[j + 8][7:4]};
            end
        end
        if (cmd.load_quant)
        begin
            cur_next = pos_reg;
            q_next   = in_data[135:128];
            pos_next = pos_reg + 7'd1;
        end
        if (cmd.do_scale)
        begin
            sc_next = q4k_pkg::SC_W'(d_m) * q4k_pkg::SC_W'(scl_reg[sub]);
            mn_next = q4k_pkg::SC_W'(m_m) * q4k_pkg::SC_W'(mnl_reg[sub]);
        end
        if (cmd.do_prod)
        begin
            p_next = q4k_pkg::PROD_W'(sc_reg) * q4k_pkg::PROD_W'(qn);
        end
        if (cmd.do_align)
        begin
            mag_next  = sum_mag;
            sgn_next  = sum_sgn;
            sh_next   = '0;
            nan_next  = p_nan || n_nan || (p_inf && n_inf && (hs_reg[15] == hm_reg[15]));
            inf_next  = p_inf || n_inf;
            infs_next = p_inf ? hs_reg[15] : !hm_reg[15];
        end
        if (cmd.do_norm && !stat.norm_done)
        begin
            mag_next = mag_reg << 8;
            sh_next  = sh_reg + q4k_pkg::SHIFT_W'(8);
        end
        if (cmd.do_round)
        begin
            od_next = {sub, cmd.sel_hi, cur_reg[3:0], val};
            ol_next = cmd.sel_hi && (cur_reg == q4k_pkg::LAST_POS);
            ov_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hs_reg  <= '0;
            hm_reg  <= '0;
            pos_reg <= '0;
            ov_reg  <= 1'b0;
            for (int j = 0; j < 8; j++)
            begin
                scl_reg[j] <= '0;
                mnl_reg[j] <= '0;
            end
        end
        else
        begin
            hs_reg  <= hs_next;
            hm_reg  <= hm_next;
            pos_reg <= pos_next;
            ov_reg  <= ov_next;
            scl_reg <= scl_next;
            mnl_reg <= mnl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg  <= cur_next;
        q_reg    <= q_next;
        sc_reg   <= sc_next;
        mn_reg   <= mn_next;
        p_reg    <= p_next;
        mag_reg  <= mag_next;
        sgn_reg  <= sgn_next;
        emin_reg <= cmd.do_align ? emin_next : emin_reg;
        sh_reg   <= sh_next;
        nan_reg  <= nan_next;
        inf_reg  <= inf_next;
        infs_reg <= infs_next;
        od_reg   <= od_next;
        ol_reg   <= ol_next;
    end

    assign out_data  = od_reg;
    assign out_last  = ol_reg;
    assign out_valid = ov_reg;

endmodule

`default_nettype wire

FILE: design/q4k_superblock_dequantizer.sv
`timescale 1ns / 1ps
`default_nettype none

// Header item: accepted with no result; the input stays ready after it.
// Quant byte: two results, low nibble then high nibble; the scale step is shared
// by both, then each passes product, align, the byte-wise normalize loop (0 to 6
// shift steps) and round. The next item is taken only after both results are
// registered; output stalls hold off the input as well.
// Reset (rst_n low, async) clears factors, scales, mins and byte position.

module q4k_superblock_dequantizer
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // scale_half, min_half, packed_bytes_low, _mid, _high, quant_byte
    input  wire logic [135:0] s_axis_tdata,
    // is_header
    input  wire logic         s_axis_tuser,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // value_bits, element_index
    output logic [39:0]       m_axis_tdata,
    output logic              m_axis_tlast
);

    q4k_pkg::cmd_t  cmd;
    q4k_pkg::stat_t stat;

    q4k_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_header (s_axis_tuser),
        .in_ready  (s_axis_tready),
        .stat      (stat),
        .cmd       (cmd)
    );

    q4k_dp u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .in_data   (s_axis_tdata),
        .out_data  (m_axis_tdata),
        .out_last  (m_axis_tlast),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready)
    );

`ifndef ASSERT_OFF
    a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tlast |-> m_axis_tdata[39:32] == 8'hFF)
        else $error("last flag on wrong element");

    a_quant_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && !s_axis_tuser |=> !s_axis_tready)
        else $error("input taken while byte in progress");

    a_hdr_ready: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tuser |=> s_axis_tready)
        else $error("header transfer stalled input");
`endif

endmodule

`default_nettype wire

FILE: tb/tb_q4k_superblock_dequantizer.sv
`timescale 1ns / 1ps

module tb_q4k_superblock_dequantizer;

    localparam int WDOG_LIMIT = 5000;
    localparam int HOLD_LEN   = 400;
    localparam int RAND_ITEMS = 1500;

    typedef struct {
        logic        hdr;
        logic [15:0] sh;
        logic [15:0] mh;
        logic [31:0] lo;
        logic [31:0] mi;
        logic [31:0] hi;
        logic [7:0]  qb;
    } sb_item_t;

    typedef struct {
        logic [31:0] value;
        logic [7:0]  index;
        logic        last;
    } elem_t;

    typedef struct {
        sb_item_t    item;
        logic        typed;
        logic [31:0] v0;
        logic [31:0] v1;
    } dir_row_t;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           s_axis_tvalid = 1'b0;
    logic                           s_axis_tready;
    logic [q4k_pkg::IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic                           s_axis_tuser = 1'b0;
    logic                           m_axis_tvalid;
    logic                           m_axis_tready = 1'b0;
    logic [q4k_pkg::OUT_DATA_W-1:0] m_axis_tdata;
    logic                           m_axis_tlast;

    // predictor state
    logic [31:0] d_bits;
    logic [31:0] dmin_bits;
    logic [5:0]  scl [8];
    logic [5:0]  mns [8];
    logic [6:0]  pos;

    elem_t exp_q[$];
    int    err_cnt = 0;
    int    res_cnt = 0;
    int    hdr_cnt = 0;
    int    qb_cnt = 0;
    int    quiet_cycles = 0;
    int    in_idle_pct = 14;
    int    out_stall_pct = 72;
    logic  hold_req = 1'b0;
    int    hold_cnt = 0;

    q4k_superblock_dequantizer u_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // ---------------- float32 arithmetic, round to nearest even ----------------

    function automatic logic f_nan(logic [31:0] f);
        return (&f[30:23]) && (|f[22:0]);
    endfunction

    function automatic logic f_inf(logic [31:0] f);
        return (&f[30:23]) && !(|f[22:0]);
    endfunction

    function automatic void f_split(input logic [31:0] f, output logic [127:0] m,
                                    output int e);
        if (f[30:23] == 8'd0)
        begin
            m = 128'(f[22:0]);
            e = -149;
        end
        else
        begin
            m = 128'({1'b1, f[22:0]});
            e = int'(f[30:23]) - 150;
        end
    endfunction

    // value = mag * 2^e, mag nonzero
    function automatic logic [31:0] f_round(logic s, logic [127:0] mag, int e);
        int p;
        int lsb;
        int sh;
        logic [127:0] kept;
        logic g;
        logic st;
        p = 127;
        while (!mag[p])
            p--;
        lsb = p + e - 23;
        if (lsb < -149)
            lsb = -149;
        sh = lsb - e;
        g = 1'b0;
        st = 1'b0;
        if (sh <= 0)
            kept = mag << (-sh);
        else if (sh > 128)
        begin
            kept = '0;
            st = 1'b1;
        end
        else
        begin
            kept = mag >> sh;
            g = mag[sh-1];
            st = |(mag & ((128'd1 << (sh - 1)) - 128'd1));
        end
        if (g && (st || kept[0]))
            kept++;
        if (kept[24])
        begin
            kept = kept >> 1;
            lsb++;
        end
        if (kept[23])
        begin
            if (lsb + 150 >= 255)
                return {s, 8'hFF, 23'd0};
            return {s, 8'(lsb + 150), kept[22:0]};
        end
        return {s, 8'd0, kept[22:0]};
    endfunction

    function automatic logic [31:0] f_mul(logic [31:0] a, logic [31:0] b);
        logic s;
        logic [127:0] ma;
        logic [127:0] mb;
        int ea;
        int eb;
        s = a[31] ^ b[31];
        if (f_nan(a) || f_nan(b))
            return q4k_pkg::CANON_NAN;
        if (f_inf(a) || f_inf(b))
        begin
            if (a[30:0] == 0 || b[30:0] == 0)
                return q4k_pkg::CANON_NAN;
            return {s, 8'hFF, 23'd0};
        end
        if (a[30:0] == 0 || b[30:0] == 0)
            return {s, 31'd0};
        f_split(a, ma, ea);
        f_split(b, mb, eb);
        return f_round(s, ma * mb, ea + eb);
    endfunction

    function automatic logic [31:0] f_add(logic [31:0] a, logic [31:0] b);
        logic [127:0] ma;
        logic [127:0] mb;
        logic [127:0] tm;
        logic [31:0] t;
        int ea;
        int eb;
        int te;
        int e;
        if (f_nan(a) || f_nan(b))
            return q4k_pkg::CANON_NAN;
        if (f_inf(a) && f_inf(b))
            return (a[31] != b[31]) ? q4k_pkg::CANON_NAN : a;
        if (f_inf(a))
            return a;
        if (f_inf(b))
            return b;
        if (a[30:0] == 0 && b[30:0] == 0)
            return {a[31] & b[31], 31'd0};
        if (a[30:0] == 0)
            return b;
        if (b[30:0] == 0)
            return a;
        f_split(a, ma, ea);
        f_split(b, mb, eb);
        if (ea < eb)
        begin
            t = a; a = b; b = t;
            tm = ma; ma = mb; mb = tm;
            te = ea; ea = eb; eb = te;
        end
        // far smaller operand only matters as a sticky bit
        if (ea - eb > 60)
        begin
            ma = ma << 60;
            mb = 128'd1;
            e = ea - 60;
        end
        else
        begin
            ma = ma << (ea - eb);
            e = eb;
        end
        if (a[31] == b[31])
            return f_round(a[31], ma + mb, e);
        if (ma > mb)
            return f_round(a[31], ma - mb, e);
        if (mb > ma)
            return f_round(b[31], mb - ma, e);
        return 32'd0;
    endfunction

    function automatic logic [31:0] u6_to_f(logic [5:0] v);
        if (v == 0)
            return 32'd0;
        return f_round(1'b0, 128'(v), 0);
    endfunction

    function automatic logic [31:0] half_widen(logic [15:0] h);
        logic [10:0] m;
        int e;
        logic [31:0] o;
        o = {h[15], 31'd0};
        m = {1'b0, h[9:0]};
        if (h[14:10] == 5'd0)
        begin
            if (m != 0)
            begin
                e = 113;
                while (!m[10])
                begin
                    m = m << 1;
                    e--;
                end
                o[30:23] = 8'(e);
                o[22:13] = m[9:0];
            end
        end
        else if (h[14:10] == 5'h1F)
            o[30:0] = {8'hFF, h[9:0], 13'd0};
        else
            o[30:0] = {8'(h[14:10] + 8'd112), h[9:0], 13'd0};
        return o;
    endfunction

    function automatic logic [31:0] dequant(int sub, logic [3:0] q);
        logic [31:0] sc;
        logic [31:0] mn;
        logic [31:0] r;
        sc = f_mul(d_bits, u6_to_f(scl[sub]));
        mn = f_mul(dmin_bits, u6_to_f(mns[sub]));
        r = f_add(f_mul(sc, u6_to_f({2'b00, q})), {~mn[31], mn[30:0]});
        return f_nan(r) ? q4k_pkg::CANON_NAN : r;
    endfunction

    function automatic void predict_elements(sb_item_t it, logic typed, logic [31:0] v0,
                                             logic [31:0] v1);
        logic [7:0] b [12];
        int sub;
        int base;
        elem_t r;
        if (it.hdr)
        begin
            for (int j = 0; j < 4; j++)
            begin
                b[j]   = it.lo[8*j +: 8];
                b[j+4] = it.mi[8*j +: 8];
                b[j+8] = it.hi[8*j +: 8];
            end
            for (int j = 0; j < 4; j++)
            begin
                scl[j]   = b[j][5:0];
                mns[j]   = b[j+4][5:0];
                scl[j+4] = {b[j][7:6], b[j+8][3:0]};
                mns[j+4] = {b[j+4][7:6], b[j+8][7:4]};
            end
            d_bits = half_widen(it.sh);
            dmin_bits = half_widen(it.mh);
            pos = '0;
        end
        else
        begin
            sub = int'(pos[6:4]);
            base = sub * 32 + int'(pos[3:0]);
            r.value = typed ? v0 : dequant(sub, it.qb[3:0]);
            r.index = 8'(base);
            r.last = 1'b0;
            exp_q.push_back(r);
            r.value = typed ? v1 : dequant(sub, it.qb[7:4]);
            r.index = 8'(base + 16);
            r.last = (pos == q4k_pkg::LAST_POS);
            exp_q.push_back(r);
            pos = pos + 7'd1;
        end
    endfunction

    // ---------------- stimulus ----------------

    task automatic send_item(sb_item_t it, logic typed = 1'b0, logic [31:0] v0 = '0,
                             logic [31:0] v1 = '0);
        logic hs;
        while ($urandom_range(99) < in_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= it.hdr;
        s_axis_tdata  <= {it.qb, it.hi, it.mi, it.lo, it.mh, it.sh};
        do
        begin
            @(negedge clk);
            hs = s_axis_tvalid && s_axis_tready;
            @(posedge clk);
        end
        while (!hs);
        if (it.hdr)
            hdr_cnt++;
        else
            qb_cnt++;
        predict_elements(it, typed, v0, v1);
    endtask

    function automatic logic [15:0] rand_half();
        logic [15:0] specials [8] = '{16'h0000, 16'h8000, 16'h7C00, 16'hFC00,
                                      16'h7E00, 16'h0001, 16'h03FF, 16'h7BFF};
        case ($urandom_range(7))
            0: return 16'($urandom);
            1: return specials[$urandom_range(7)];
            default: return {1'($urandom), 5'($urandom_range(22, 8)), 10'($urandom)};
        endcase
    endfunction

    function automatic sb_item_t rand_item(logic hdr);
        sb_item_t it;
        it.hdr = hdr;
        it.sh = rand_half();
        it.mh = rand_half();
        it.lo = $urandom;
        it.mi = $urandom;
        it.hi = $urandom;
        it.qb = 8'($urandom);
        return it;
    endfunction

    dir_row_t dir_rows [19] = '{
        // quant bytes before any header: all-zero state gives +0.0
        '{'{1'b0, 16'h0000, 16'h0000, 32'h0, 32'h0, 32'h0, 8'hFF}, 1'b1, 32'h0, 32'h0},
        '{'{1'b0, 16'h0000, 16'h0000, 32'h0, 32'h0, 32'h0, 8'h00}, 1'b1, 32'h0, 32'h0},
        '{'{1'b1, 16'h3C00, 16'h3C00, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 8'h00},
          1'b0, 32'h0, 32'h0},
        '{'{1'b0, 16'h0, 16'h0, 32'h0, 32'h0, 32'h0, 8'hFF}, 1'b0, 32'h0, 32'h0},
        '{'{1'b0, 16'h0, 16'h0, 32'h0, 32'h0, 32'h0, 8'h00}, 1'b0, 32'h0, 32'h0},
        '{'{1'b0, 16'h0, 16'h0, 32'h0, 32'h0, 32'h0, 8'h0F}, 1'b0, 32'h0, 32'h0},
        '{'{1'b1, 16'h7BFF, 16'h0001, 32'h3F3F3F3F, 32'h0, 32'hF0F0F00F, 8'hFF},
          1'b0, 32'h0, 32'h0},
        '{'{1'b0, 16'hFFFF, 16'hFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 8'hA5},
          1'b0, 32'h0, 32'h0},
        // infinite factor times a zero quant nibble: canonical NaN
        '{'{1'b1, 16'h7C00, 16'h3C00, 32'h00000001, 32'h01010101, 32'h0, 8'h00},
          1'b0, 32'h0, 32'h0},
        '{'{1'b0, 16'h0, 16'h0, 32'h0, 32'h0, 32'h0, 8'h10}, 1'b0, 32'h0, 32'h0},
        '{'{1'b0, 16'h0, 16'h0, 32'h0, 32'h0, 32'h0, 8'h00}, 1'b0, 32'h0, 32'h0},
        '{'{1'b1, 16'h7E01, 16'hFC00, 32'h01020304, 32'h05060708, 32'h090A0B0C, 8'h00},
          1'b0, 32'h0, 32'h0},
        '{'{1'b0, 16'h0, 16'h0, 32'h0, 32'h0, 32'h0, 8'h5A}, 1'b0, 32'h0, 32'h0},
        '{'{1'b1, 16'h8400, 16'h0400, 32'hC0C0C0C0, 32'hC0C0C0C0, 32'h12345678, 8'h00},
          1'b0, 32'h0, 32'h0},
        '{'{1'b0, 16'h0, 16'h0, 32'h0, 32'h0, 32'h0, 8'hFF}, 1'b0, 32'h0, 32'h0},
        '{'{1'b1, 16'h0000, 16'h8000, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 8'h00},
          1'b0, 32'h0, 32'h0},
        '{'{1'b0, 16'h0, 16'h0, 32'h0, 32'h0, 32'h0, 8'h3C}, 1'b0, 32'h0, 32'h0},
        '{'{1'b1, 16'h3555, 16'h83FF, 32'h87654321, 32'h0F1E2D3C, 32'hA5A55A5A, 8'h00},
          1'b0, 32'h0, 32'h0},
        '{'{1'b0, 16'h0, 16'h0, 32'h0, 32'h0, 32'h0, 8'h11}, 1'b0, 32'h0, 32'h0}
    };

    // receiver; one long hold-off once the last phase starts
    always @(posedge clk)
    begin
        if (hold_req && hold_cnt < HOLD_LEN)
        begin
            hold_cnt <= hold_cnt + 1;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= ($urandom_range(99) >= out_stall_pct);
    end

    // output check and watchdog
    always @(negedge clk)
    begin
        elem_t e;
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WDOG_LIMIT)
            begin
                $display("tb_q4k_superblock_dequantizer NOT OK");
                $finish;
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                res_cnt++;
                if (exp_q.size() == 0)
                begin
                    $display("%0t: unexpected element %h idx %0d", $time,
                             m_axis_tdata[31:0], m_axis_tdata[39:32]);
                    err_cnt++;
                end
                else
                begin
                    e = exp_q.pop_front();
                    if (m_axis_tdata[31:0] !== e.value)
                    begin
                        $display("%0t: value mismatch idx %0d exp %h got %h", $time,
                                 e.index, e.value, m_axis_tdata[31:0]);
                        err_cnt++;
                    end
                    if (m_axis_tdata[39:32] !== e.index)
                    begin
                        $display("%0t: index mismatch exp %0d got %0d", $time,
                                 e.index, m_axis_tdata[39:32]);
                        err_cnt++;
                    end
                    if (m_axis_tlast !== e.last)
                    begin
                        $display("%0t: tlast mismatch idx %0d exp %b got %b", $time,
                                 e.index, e.last, m_axis_tlast);
                        err_cnt++;
                    end
                end
            end
        end
    end

    initial
    begin
        int n;
        int len;
        d_bits = '0;
        dmin_bits = '0;
        pos = '0;
        for (int j = 0; j < 8; j++)
        begin
            scl[j] = '0;
            mns[j] = '0;
        end
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[r])
            send_item(dir_rows[r].item, dir_rows[r].typed, dir_rows[r].v0, dir_rows[r].v1);

        n = 0;
        while (n < RAND_ITEMS)
        begin
            send_item(rand_item(1'b1));
            n++;
            len = ($urandom_range(9) == 0) ? $urandom_range(200, 1) : 128;
            for (int k = 0; k < len && n < RAND_ITEMS; k++)
            begin
                if (n < RAND_ITEMS / 3)
                begin
                    in_idle_pct = 14;
                    out_stall_pct <= 72;
                end
                else if (n < 2 * RAND_ITEMS / 3)
                begin
                    in_idle_pct = 72;
                    out_stall_pct <= 14;
                end
                else
                begin
                    in_idle_pct = 0;
                    out_stall_pct <= 0;
                    hold_req <= 1'b1;
                end
                // stray header breaks the current super-block
                send_item(rand_item($urandom_range(299) == 0));
                n++;
            end
        end
        s_axis_tvalid <= 1'b0;

        while (exp_q.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);

        $display("Sent %0d headers and %0d quant bytes, checked %0d elements", hdr_cnt,
                 qb_cnt, res_cnt);
        $display("covered pre-header bytes, special halves, position wrap, stalls");
        if (err_cnt == 0 && exp_q.size() == 0)
            $display("tb_q4k_superblock_dequantizer OK");
        else
            $display("tb_q4k_superblock_dequantizer NOT OK");
        $finish;
    end

endmodule
